@@ sv/dasc_pkg.sv @@
// ============================================================================
// dasc_pkg: shared types and constants of the deadlock avoidance check
// Operation and status codes, default sizes, controller command types.
// ============================================================================
package dasc_pkg;

   localparam int MAX_PROCESSES_DEF = 8;
   localparam int MAX_RESOURCES_DEF = 4;

   localparam logic [2:0] OP_WR_ALLOC = 3'd0;
   localparam logic [2:0] OP_WR_MAX   = 3'd1;
   localparam logic [2:0] OP_WR_AVAIL = 3'd2;
   localparam logic [2:0] OP_CHECK    = 3'd3;
   localparam logic [2:0] OP_REQUEST  = 3'd4;

   localparam logic [2:0] ST_WRITTEN  = 3'd0;
   localparam logic [2:0] ST_SAFE     = 3'd1;
   localparam logic [2:0] ST_UNSAFE   = 3'd2;
   localparam logic [2:0] ST_EXCEEDS  = 3'd3;
   localparam logic [2:0] ST_WAIT     = 3'd4;
   localparam logic [2:0] ST_BAD_IDX  = 3'd5;

   localparam logic CSR_NUM_PROCS = 1'b0;
   localparam logic CSR_NUM_RES   = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic do_write;     // write the table entry given by the item
      logic start_check;  // load working availability, clear marks
      logic use_trial;    // check with the request added to one process
      logic step;         // test one process against working availability
      logic commit;       // commit the request to the tables
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic bad_index;
      logic exceeds;
      logic must_wait;
      logic all_found;    // every process placed in the sequence
   } stat_type;

endpackage

@@ sv/dasc_datapath.sv @@
// ============================================================================
// dasc_datapath: tables, working availability and sequence buffer
// Holds the state and does one process test per step command.
// ============================================================================
module dasc_datapath #(
   parameter int MAX_PROCESSES = dasc_pkg::MAX_PROCESSES_DEF,
   parameter int MAX_RESOURCES = dasc_pkg::MAX_RESOURCES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dasc_pkg::cmd_type cmd,
   input  logic [2:0]        op,
   input  logic [2:0]        pid,
   input  logic [1:0]        res,
   input  logic [7:0]        val,
   input  logic [31:0]       req_units,
   input  logic [3:0]        n_eff,
   input  logic [3:0]        r_eff,
   input  logic [3:0]        cur_proc,
   input  logic [3:0]        seq_rd,
   output dasc_pkg::stat_type stat,
   output logic [2:0]        seq_out
);
   import dasc_pkg::*;

   localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

   logic [7:0]  alloc_ff [MAX_PROCESSES][MAX_RESOURCES];
   logic [7:0]  max_ff   [MAX_PROCESSES][MAX_RESOURCES];
   logic [7:0]  avail_ff [MAX_RESOURCES];
   logic [15:0] work_ff  [MAX_RESOURCES];
   logic [MAX_PROCESSES-1:0] fin_ff;
   logic [2:0]  seq_ff   [MAX_PROCESSES];
   logic [4:0]  cnt_ff;

   logic [7:0]  reqv [MAX_RESOURCES];
   logic [PW-1:0] pi, ci;
   logic        pid_ok, res_ok;
   logic        fits;
   logic [8:0]  ca [MAX_RESOURCES];

   assign pi = pid[PW-1:0];
   assign ci = cur_proc[PW-1:0];
   assign pid_ok = ({1'b0, pid} < n_eff);
   assign res_ok = ({2'b0, res} < r_eff);

   always_comb begin
      for (int j = 0; j < MAX_RESOURCES; j++) begin
         if (j < 4 && j < int'(r_eff)) reqv[j] = req_units[j*8 +: 8];
         else reqv[j] = 8'd0;
      end
   end

   // Allocation of the current process, with the request added in trial mode.
   always_comb begin
      for (int j = 0; j < MAX_RESOURCES; j++) begin
         ca[j] = {1'b0, alloc_ff[ci][j]};
         if (cmd.use_trial && ci == pi) ca[j] = ca[j] + {1'b0, reqv[j]};
      end
   end

   always_comb begin
      fits = !fin_ff[ci];
      for (int j = 0; j < MAX_RESOURCES; j++) begin
         if (j < int'(r_eff) &&
             $signed({1'b0, max_ff[ci][j]}) - $signed(ca[j]) >
             $signed({2'b0, work_ff[j]})) fits = 1'b0;
      end
   end

   always_comb begin
      stat.bad_index = 1'b0;
      unique case (op)
         OP_WR_ALLOC, OP_WR_MAX: stat.bad_index = !(pid_ok && res_ok);
         OP_WR_AVAIL:            stat.bad_index = !res_ok;
         OP_CHECK:               stat.bad_index = 1'b0;
         OP_REQUEST:             stat.bad_index = !pid_ok;
         default:                stat.bad_index = 1'b1;
      endcase
      stat.exceeds = 1'b0;
      stat.must_wait = 1'b0;
      // A negative need is exceeded by any request, even an all-zero one.
      for (int j = 0; j < MAX_RESOURCES; j++) begin
         if (j < int'(r_eff) &&
             ({1'b0, reqv[j]} > max_ff[pi][j] - {1'b0, alloc_ff[pi][j]} ||
              max_ff[pi][j] < alloc_ff[pi][j]))
            stat.exceeds = 1'b1;
         if (reqv[j] > avail_ff[j]) stat.must_wait = 1'b1;
      end
      stat.all_found = (cnt_ff == {1'b0, n_eff});
   end

   assign seq_out = seq_ff[seq_rd[PW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < MAX_PROCESSES; p++)
            for (int j = 0; j < MAX_RESOURCES; j++) begin
               alloc_ff[p][j] <= 8'd0;
               max_ff[p][j]   <= 8'd0;
            end
         for (int j = 0; j < MAX_RESOURCES; j++) avail_ff[j] <= 8'd0;
         fin_ff <= '0;
         cnt_ff <= 5'd0;
      end else begin
         if (cmd.do_write) begin
            if (op == OP_WR_ALLOC) alloc_ff[pi][res] <= val;
            else if (op == OP_WR_MAX) max_ff[pi][res] <= val;
            else avail_ff[res] <= val;
         end
         if (cmd.start_check) begin
            fin_ff <= '0;
            cnt_ff <= 5'd0;
            for (int j = 0; j < MAX_RESOURCES; j++)
               work_ff[j] <= cmd.use_trial ? {8'd0, avail_ff[j] - reqv[j]}
                                           : {8'd0, avail_ff[j]};
         end
         if (cmd.step && fits) begin
            seq_ff[cnt_ff[PW-1:0]] <= cur_proc[2:0];
            cnt_ff <= cnt_ff + 5'd1;
            fin_ff[ci] <= 1'b1;
            for (int j = 0; j < MAX_RESOURCES; j++)
               if (j < int'(r_eff))
                  work_ff[j] <= ({1'b0, work_ff[j]} + {8'd0, ca[j]} > 17'hFFFF) ?
                     16'hFFFF : work_ff[j] + {7'd0, ca[j]};
         end
         if (cmd.commit) begin
            for (int j = 0; j < MAX_RESOURCES; j++) begin
               alloc_ff[pi][j] <= alloc_ff[pi][j] + reqv[j];
               avail_ff[j] <= avail_ff[j] - reqv[j];
            end
         end
      end
   end
endmodule

@@ sv/dasc_ctrl.sv @@
// ============================================================================
// dasc_ctrl: controller of the deadlock avoidance check
// Sequences item intake, check passes and result delivery.
// ============================================================================
module dasc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [2:0]        in_op,
   output logic [2:0]        op,
   input  logic [3:0]        n_eff,
   input  dasc_pkg::stat_type stat,
   output dasc_pkg::cmd_type cmd,
   output logic [3:0]        cur_proc,
   output logic [3:0]        seq_rd,
   input  logic [2:0]        seq_out,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2:0]        out_status,
   output logic [2:0]        out_seq,
   output logic              out_last
);
   import dasc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEC   = 3'd1;
   localparam logic [2:0] S_RUN   = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_ONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] op_ff;
   logic [3:0] proc_ff, pass_ff, rd_ff;
   logic       trial_ff;
   logic       ov_ff, ov_in;
   logic [2:0] os_ff, oq_ff, ps_ff;
   logic       ol_ff;
   logic       out_free;

   assign op = op_ff;
   assign cur_proc = proc_ff;
   assign seq_rd = rd_ff;
   assign out_valid = ov_ff;
   assign out_status = os_ff;
   assign out_seq = oq_ff;
   assign out_last = ol_ff;
   assign out_free = !ov_ff || out_ready;
   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      cmd.use_trial = trial_ff;
      unique case (state_ff)
         S_DEC: begin
            if (!stat.bad_index) begin
               if (op_ff == OP_CHECK) cmd.start_check = 1'b1;
               else if (op_ff == OP_REQUEST) begin
                  cmd.start_check = !stat.exceeds && !stat.must_wait;
                  cmd.use_trial = 1'b1;
               end else cmd.do_write = 1'b1;
            end
         end
         S_RUN: cmd.step = 1'b1;
         S_EMIT: cmd.commit = trial_ff && rd_ff == 4'd0 && out_free;
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (in_valid) state_in = S_DEC;
         S_DEC:
            if (stat.bad_index || (op_ff != OP_CHECK && op_ff != OP_REQUEST) ||
                (op_ff == OP_REQUEST && (stat.exceeds || stat.must_wait)))
               state_in = S_ONE;
            else state_in = S_RUN;
         S_RUN:
            if (proc_ff + 4'd1 == n_eff && pass_ff + 4'd1 == n_eff)
               state_in = S_ONE;
         S_ONE: if (out_free) state_in = S_IDLE;
         S_EMIT: if (out_free && rd_ff + 4'd1 == n_eff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_ONE && (op_ff == OP_CHECK || op_ff == OP_REQUEST) &&
          !stat.bad_index && stat.all_found && trial_ff == (op_ff == OP_REQUEST))
         state_in = S_EMIT;
   end

   // The output register is loaded only when it is free or being taken.
   always_comb begin
      ov_in = ov_ff && !out_ready;
      if ((state_ff == S_ONE && state_in == S_IDLE) ||
          (state_ff == S_EMIT && out_free))
         ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
         trial_ff <= 1'b0;
         proc_ff <= 4'd0;
         pass_ff <= 4'd0;
         rd_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         unique case (state_ff)
            S_IDLE: if (in_valid) begin
               op_ff <= in_op;
               trial_ff <= 1'b0;
            end
            S_DEC: begin
               proc_ff <= 4'd0;
               pass_ff <= 4'd0;
               rd_ff <= 4'd0;
               trial_ff <= (op_ff == OP_REQUEST) && !stat.bad_index &&
                           !stat.exceeds && !stat.must_wait;
               if (stat.bad_index) ps_ff <= ST_BAD_IDX;
               else if (op_ff == OP_REQUEST && stat.exceeds) ps_ff <= ST_EXCEEDS;
               else if (op_ff == OP_REQUEST) ps_ff <= ST_WAIT;
               else ps_ff <= ST_WRITTEN;
            end
            S_RUN: begin
               if (proc_ff + 4'd1 == n_eff) begin
                  proc_ff <= 4'd0;
                  pass_ff <= pass_ff + 4'd1;
               end else proc_ff <= proc_ff + 4'd1;
               ps_ff <= ST_UNSAFE;
            end
            S_ONE: if (out_free && state_in == S_IDLE) begin
               os_ff <= ps_ff;
               oq_ff <= 3'd0;
               ol_ff <= 1'b1;
            end
            S_EMIT: if (out_free) begin
               os_ff <= ST_SAFE;
               oq_ff <= seq_out;
               ol_ff <= (rd_ff + 4'd1 == n_eff);
               rd_ff <= rd_ff + 4'd1;
               trial_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end
endmodule

@@ sv/deadlock_avoidance_safety_check.sv @@
// ============================================================================
// deadlock_avoidance_safety_check: banker's algorithm safety check
// Channel | dir | contents
// req_    | in  | tdata: operation, process_index, resource_index, entry_value,
//         |     |        request_0..request_3
// rsp_    | out | tdata: status, sequence_process; tlast: last
// csr_    | in  | wr_en, index, wdata (num_processes, num_resources)
// A write, an error or a rejected request goes through intake, decode and
// result hand-off before the next acceptance. A check or a tentative request
// goes through intake, decode, N*N process tests (one process test per cycle),
// hand-off and delivery of its results, one per cycle while rsp_ is not stalled.
// Reset is synchronous and clears the tables. A stalled rsp_ holds the block.
// ============================================================================
module deadlock_avoidance_safety_check #(
   parameter int MAX_PROCESSES = dasc_pkg::MAX_PROCESSES_DEF,
   parameter int MAX_RESOURCES = dasc_pkg::MAX_RESOURCES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[2:0], process_index[5:3], resource_index[7:6], entry_value[15:8],
   // request_0[23:16], request_1[31:24], request_2[39:32], request_3[47:40]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], sequence_process[5:3]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);
   import dasc_pkg::*;

   logic [3:0] np_ff;
   logic [2:0] nr_ff;
   logic [3:0] n_eff, r_eff;
   logic [47:0] item_ff;
   cmd_type  cmd;
   stat_type stat;
   logic [2:0] op, seq_out, st, sq;
   logic [3:0] cur_proc, seq_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff <= 4'd8;
         nr_ff <= 3'd4;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_NUM_PROCS) np_ff <= csr_wdata;
         else nr_ff <= csr_wdata[2:0];
      end
   end

   always_ff @(posedge clock)
      if (req_tvalid && req_tready) item_ff <= req_tdata;

   assign n_eff = (np_ff == 4'd0) ? 4'd1 :
                  ({28'd0, np_ff} > MAX_PROCESSES) ? 4'(MAX_PROCESSES) : np_ff;
   assign r_eff = (nr_ff == 3'd0) ? 4'd1 :
                  ({29'd0, nr_ff} > MAX_RESOURCES) ? 4'(MAX_RESOURCES)
                                                   : {1'b0, nr_ff};

   dasc_datapath #(.MAX_PROCESSES(MAX_PROCESSES), .MAX_RESOURCES(MAX_RESOURCES))
   u_dp (
      .clock, .reset, .cmd,
      .op(item_ff[2:0]), .pid(item_ff[5:3]), .res(item_ff[7:6]),
      .val(item_ff[15:8]), .req_units(item_ff[47:16]),
      .n_eff, .r_eff, .cur_proc, .seq_rd, .stat, .seq_out
   );

   dasc_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_op(req_tdata[2:0]),
      .op, .n_eff, .stat, .cmd, .cur_proc, .seq_rd, .seq_out,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_status(st), .out_seq(sq), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {2'b00, sq, st};
endmodule
